/* rtl/mwcd_pkg.sv */
// Shared widths, reset values and codes for the masked weighted category draw.
`timescale 1ns / 1ps
`default_nettype none

package mwcd_pkg;

   // Field widths of the request and response words
   localparam int MASK_WIDTH   = 8;
   localparam int DRAW_WIDTH   = 16;
   localparam int TAG_WIDTH    = 16;
   localparam int WEIGHT_WIDTH = 16;
   localparam int CAT_WIDTH    = 4;

   // Category count limits
   localparam int MAX_CATEGORIES         = 8;
   localparam int DEFAULT_NUM_CATEGORIES = 8;

   // Register port: weight_i sits at index i
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WEIGHT_0 = 3'd0;

   // Reset weight, Q0.16 one eighth
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_RESET = 16'd8192;

   // Result code when no category matches
   localparam logic signed [CAT_WIDTH-1:0] NO_CATEGORY = -4'sd1;

endpackage

`default_nettype wire

/* rtl/mwcd_req_if.sv */
// Request channel: one read word with mask, draw and tag.
`timescale 1ns / 1ps
`default_nettype none

interface mwcd_req_if;
   logic                              valid;
   logic                              ready;
   logic [mwcd_pkg::MASK_WIDTH-1:0]   match_mask;
   logic [mwcd_pkg::DRAW_WIDTH-1:0]   uniform_draw;
   logic [mwcd_pkg::TAG_WIDTH-1:0]    read_tag;

   modport source (output valid, output match_mask, output uniform_draw, output read_tag,
                   input ready);
   modport sink   (input valid, input match_mask, input uniform_draw, input read_tag,
                   output ready);
endinterface

`default_nettype wire

/* rtl/mwcd_rsp_if.sv */
// Response channel: chosen category and the read tag.
`timescale 1ns / 1ps
`default_nettype none

interface mwcd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mwcd_pkg::CAT_WIDTH-1:0] chosen_category;
   logic [mwcd_pkg::TAG_WIDTH-1:0]      tag_out;

   modport source (output valid, output chosen_category, output tag_out, input ready);
   modport sink   (input valid, input chosen_category, input tag_out, output ready);
endinterface

`default_nettype wire

/* rtl/mwcd_weights.sv */
// Weight register file written through the configuration port.
`timescale 1ns / 1ps
`default_nettype none

module mwcd_weights #(
   parameter int NUM_CATEGORIES = mwcd_pkg::DEFAULT_NUM_CATEGORIES
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [mwcd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [mwcd_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output logic [NUM_CATEGORIES-1:0][mwcd_pkg::WEIGHT_WIDTH-1:0] weights
);

   localparam int IDX_WIDTH = $clog2(NUM_CATEGORIES);
   localparam logic [mwcd_pkg::CSR_INDEX_WIDTH:0] CAT_COUNT =
      (mwcd_pkg::CSR_INDEX_WIDTH + 1)'(NUM_CATEGORIES);

   logic [NUM_CATEGORIES-1:0][mwcd_pkg::WEIGHT_WIDTH-1:0] weights_ff;
   logic [mwcd_pkg::CSR_INDEX_WIDTH:0]                     offset;
   logic                                                   hit;

   // Drop writes to indexes past the last category
   assign offset = {1'b0, csr_index} - {1'b0, mwcd_pkg::REG_WEIGHT_0};
   assign hit    = csr_we && (offset < CAT_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_CATEGORIES; j++) begin
            weights_ff[j] <= mwcd_pkg::WEIGHT_RESET;
         end
      end else if (hit) begin
         weights_ff[offset[IDX_WIDTH-1:0]] <= csr_wdata[mwcd_pkg::WEIGHT_WIDTH-1:0];
      end
   end

   assign weights = weights_ff;

endmodule

`default_nettype wire

/* rtl/mwcd_accum.sv */
// Input register and running sums of the masked weights.
`timescale 1ns / 1ps
`default_nettype none

module mwcd_accum #(
   parameter int NUM_CATEGORIES = mwcd_pkg::DEFAULT_NUM_CATEGORIES,
   parameter int SUM_WIDTH      = mwcd_pkg::WEIGHT_WIDTH + $clog2(NUM_CATEGORIES)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   mwcd_req_if.sink                                 req_bus,
   input  wire logic [NUM_CATEGORIES-1:0][mwcd_pkg::WEIGHT_WIDTH-1:0] weights,
   output logic                                     sum_valid,
   input  wire logic                                sum_ready,
   output logic [NUM_CATEGORIES-1:0][SUM_WIDTH-1:0] sum_cum,
   output logic [NUM_CATEGORIES-1:0]                sum_mask,
   output logic [mwcd_pkg::DRAW_WIDTH-1:0]          sum_draw,
   output logic [mwcd_pkg::TAG_WIDTH-1:0]           sum_tag
);

   logic                                     in_valid_ff;
   logic [NUM_CATEGORIES-1:0]                in_mask_ff;
   logic [mwcd_pkg::DRAW_WIDTH-1:0]          in_draw_ff;
   logic [mwcd_pkg::TAG_WIDTH-1:0]           in_tag_ff;
   logic                                     in_ready;

   logic                                     sum_valid_ff;
   logic [NUM_CATEGORIES-1:0][SUM_WIDTH-1:0] cum_ff;
   logic [NUM_CATEGORIES-1:0][SUM_WIDTH-1:0] cum_in;
   logic [NUM_CATEGORIES-1:0]                mask_ff;
   logic [mwcd_pkg::DRAW_WIDTH-1:0]          draw_ff;
   logic [mwcd_pkg::TAG_WIDTH-1:0]           tag_ff;
   logic                                     stage_ready;

   // Each stage takes a word when empty or when its word moves on
   assign stage_ready  = !sum_valid_ff || sum_ready;
   assign in_ready     = !in_valid_ff || stage_ready;
   assign req_bus.ready = in_ready;

   // Capture the request word; mask bits past the last category are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_bus.valid) begin
         in_mask_ff <= req_bus.match_mask[NUM_CATEGORIES-1:0];
         in_draw_ff <= req_bus.uniform_draw;
         in_tag_ff  <= req_bus.read_tag;
      end
   end

   // Running sum of masked weights in index order; the last entry is the total
   always_comb begin
      logic [SUM_WIDTH-1:0] acc;
      acc = '0;
      for (int j = 0; j < NUM_CATEGORIES; j++) begin
         if (in_mask_ff[j]) begin
            acc = acc + SUM_WIDTH'(weights[j]);
         end
         cum_in[j] = acc;
      end
   end

   // Hold the sums for the scale stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (stage_ready) begin
         sum_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready && in_valid_ff) begin
         cum_ff  <= cum_in;
         mask_ff <= in_mask_ff;
         draw_ff <= in_draw_ff;
         tag_ff  <= in_tag_ff;
      end
   end

   assign sum_valid = sum_valid_ff;
   assign sum_cum   = cum_ff;
   assign sum_mask  = mask_ff;
   assign sum_draw  = draw_ff;
   assign sum_tag   = tag_ff;

endmodule

`default_nettype wire

/* rtl/mwcd_scale.sv */
// Scale the uniform draw by the masked total (truncated Q0.16 product).
`timescale 1ns / 1ps
`default_nettype none

module mwcd_scale #(
   parameter int NUM_CATEGORIES = mwcd_pkg::DEFAULT_NUM_CATEGORIES,
   parameter int SUM_WIDTH      = mwcd_pkg::WEIGHT_WIDTH + $clog2(NUM_CATEGORIES)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                sum_valid,
   output logic                                     sum_ready,
   input  wire logic [NUM_CATEGORIES-1:0][SUM_WIDTH-1:0] sum_cum,
   input  wire logic [NUM_CATEGORIES-1:0]           sum_mask,
   input  wire logic [mwcd_pkg::DRAW_WIDTH-1:0]     sum_draw,
   input  wire logic [mwcd_pkg::TAG_WIDTH-1:0]      sum_tag,
   output logic                                     scl_valid,
   input  wire logic                                scl_ready,
   output logic [SUM_WIDTH-1:0]                     scl_scaled,
   output logic [NUM_CATEGORIES-1:0][SUM_WIDTH-1:0] scl_cum,
   output logic [NUM_CATEGORIES-1:0]                scl_mask,
   output logic [mwcd_pkg::TAG_WIDTH-1:0]           scl_tag
);

   localparam int PROD_WIDTH = mwcd_pkg::DRAW_WIDTH + SUM_WIDTH;

   logic                                     valid_ff;
   logic [SUM_WIDTH-1:0]                     scaled_ff;
   logic [SUM_WIDTH-1:0]                     scaled_in;
   logic [PROD_WIDTH-1:0]                    product;
   logic [NUM_CATEGORIES-1:0][SUM_WIDTH-1:0] cum_ff;
   logic [NUM_CATEGORIES-1:0]                mask_ff;
   logic [mwcd_pkg::TAG_WIDTH-1:0]           tag_ff;

   assign sum_ready = !valid_ff || scl_ready;

   // Multiply by the total and drop the 16 fraction bits
   assign product   = PROD_WIDTH'(sum_draw) * PROD_WIDTH'(sum_cum[NUM_CATEGORIES-1]);
   assign scaled_in = product[mwcd_pkg::DRAW_WIDTH +: SUM_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sum_ready) begin
         valid_ff <= sum_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && sum_valid) begin
         scaled_ff <= scaled_in;
         cum_ff    <= sum_cum;
         mask_ff   <= sum_mask;
         tag_ff    <= sum_tag;
      end
   end

   assign scl_valid  = valid_ff;
   assign scl_scaled = scaled_ff;
   assign scl_cum    = cum_ff;
   assign scl_mask   = mask_ff;
   assign scl_tag    = tag_ff;

endmodule

`default_nettype wire

/* rtl/mwcd_pick.sv */
// Compare the scaled draw with the running sums and register the chosen category.
`timescale 1ns / 1ps
`default_nettype none

module mwcd_pick #(
   parameter int NUM_CATEGORIES = mwcd_pkg::DEFAULT_NUM_CATEGORIES,
   parameter int SUM_WIDTH      = mwcd_pkg::WEIGHT_WIDTH + $clog2(NUM_CATEGORIES)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                scl_valid,
   output logic                                     scl_ready,
   input  wire logic [SUM_WIDTH-1:0]                scl_scaled,
   input  wire logic [NUM_CATEGORIES-1:0][SUM_WIDTH-1:0] scl_cum,
   input  wire logic [NUM_CATEGORIES-1:0]           scl_mask,
   input  wire logic [mwcd_pkg::TAG_WIDTH-1:0]      scl_tag,
   mwcd_rsp_if.source                               rsp_bus
);

   localparam int CNT_WIDTH = $clog2(NUM_CATEGORIES + 1);
   localparam logic [CNT_WIDTH-1:0] PAIR = CNT_WIDTH'(2);

   logic                                   valid_ff;
   logic signed [mwcd_pkg::CAT_WIDTH-1:0]  chosen_ff;
   logic signed [mwcd_pkg::CAT_WIDTH-1:0]  chosen_in;
   logic [mwcd_pkg::TAG_WIDTH-1:0]         tag_ff;
   logic [CNT_WIDTH-1:0]                   count;
   logic                                   strict;
   logic [NUM_CATEGORIES-1:0]              hit;
   logic [mwcd_pkg::CAT_WIDTH-1:0]         first_hit;
   logic [mwcd_pkg::CAT_WIDTH-1:0]         last_set;

   assign scl_ready = !valid_ff || rsp_bus.ready;

   // Count masked categories; exactly two switches to a strict compare
   always_comb begin
      count = '0;
      for (int j = 0; j < NUM_CATEGORIES; j++) begin
         count = count + CNT_WIDTH'(scl_mask[j]);
      end
   end

   assign strict = (count == PAIR);

   // Flag masked categories whose running sum bounds the scaled draw
   always_comb begin
      for (int j = 0; j < NUM_CATEGORIES; j++) begin
         hit[j] = scl_mask[j] && (strict ? (scl_scaled < scl_cum[j])
                                         : (scl_scaled <= scl_cum[j]));
      end
   end

   // Lowest flagged category and highest masked category
   always_comb begin
      first_hit = '0;
      last_set  = '0;
      for (int j = NUM_CATEGORIES - 1; j >= 0; j--) begin
         if (hit[j]) begin
            first_hit = mwcd_pkg::CAT_WIDTH'(j);
         end
      end
      for (int j = 0; j < NUM_CATEGORIES; j++) begin
         if (scl_mask[j]) begin
            last_set = mwcd_pkg::CAT_WIDTH'(j);
         end
      end
   end

   // Fall back to the last masked category when the strict compare misses; an empty mask gives NO_CATEGORY
   always_comb begin
      priority if (|hit) begin
         chosen_in = first_hit;
      end else if (|scl_mask) begin
         chosen_in = last_set;
      end else begin
         chosen_in = mwcd_pkg::NO_CATEGORY;
      end
   end

   // Result register, held while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (scl_ready) begin
         valid_ff <= scl_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (scl_ready && scl_valid) begin
         chosen_ff <= chosen_in;
         tag_ff    <= scl_tag;
      end
   end

   assign rsp_bus.valid           = valid_ff;
   assign rsp_bus.chosen_category = chosen_ff;
   assign rsp_bus.tag_out         = tag_ff;

endmodule

`default_nettype wire

/* rtl/masked_weighted_category_draw.sv */
// Top level of the masked weighted category draw.
//
// Usage:
//   req_bus carries one read word: match_mask, uniform_draw (Q0.16) and read_tag.
//   rsp_bus returns one word per read: chosen_category (signed, -1 when the
//   mask selects nothing) and tag_out, a copy of read_tag. Words leave in order.
//   csr_we / csr_index / csr_wdata write weight_0..weight_7 (Q0.16); write
//   only while no read is in flight. Indexes past the last category are dropped.
// Timing:
//   Four register stages: input, running sums, scaled draw, result. A word
//   passes through them in that order on its way to rsp_bus. One word is
//   accepted per cycle while rsp_bus.ready stays high; the 16x19 multiply and
//   the 8-term running sum each sit in a stage of their own.
// Reset:
//   All stages empty, every weight back to 8192.
// Stalls:
//   The result register holds its word while rsp_bus.ready is low; stages
//   upstream keep filling their empty slots, so up to four words are buffered
//   before req_bus.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module masked_weighted_category_draw #(
   parameter int NUM_CATEGORIES = mwcd_pkg::DEFAULT_NUM_CATEGORIES
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   mwcd_req_if.sink                                  req_bus,
   mwcd_rsp_if.source                                rsp_bus,
   input  wire logic                                 csr_we,
   input  wire logic [mwcd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [mwcd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int SUM_WIDTH = mwcd_pkg::WEIGHT_WIDTH + $clog2(NUM_CATEGORIES);

   logic [NUM_CATEGORIES-1:0][mwcd_pkg::WEIGHT_WIDTH-1:0] weights;

   logic                                     sum_valid;
   logic                                     sum_ready;
   logic [NUM_CATEGORIES-1:0][SUM_WIDTH-1:0] sum_cum;
   logic [NUM_CATEGORIES-1:0]                sum_mask;
   logic [mwcd_pkg::DRAW_WIDTH-1:0]          sum_draw;
   logic [mwcd_pkg::TAG_WIDTH-1:0]           sum_tag;

   logic                                     scl_valid;
   logic                                     scl_ready;
   logic [SUM_WIDTH-1:0]                     scl_scaled;
   logic [NUM_CATEGORIES-1:0][SUM_WIDTH-1:0] scl_cum;
   logic [NUM_CATEGORIES-1:0]                scl_mask;
   logic [mwcd_pkg::TAG_WIDTH-1:0]           scl_tag;

   // Weight registers
   mwcd_weights #(
      .NUM_CATEGORIES (NUM_CATEGORIES)
   ) u_weights (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .weights   (weights)
   );

   // Input register and running sums
   mwcd_accum #(
      .NUM_CATEGORIES (NUM_CATEGORIES),
      .SUM_WIDTH      (SUM_WIDTH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .weights   (weights),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready),
      .sum_cum   (sum_cum),
      .sum_mask  (sum_mask),
      .sum_draw  (sum_draw),
      .sum_tag   (sum_tag)
   );

   // Scaled draw
   mwcd_scale #(
      .NUM_CATEGORIES (NUM_CATEGORIES),
      .SUM_WIDTH      (SUM_WIDTH)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .sum_valid  (sum_valid),
      .sum_ready  (sum_ready),
      .sum_cum    (sum_cum),
      .sum_mask   (sum_mask),
      .sum_draw   (sum_draw),
      .sum_tag    (sum_tag),
      .scl_valid  (scl_valid),
      .scl_ready  (scl_ready),
      .scl_scaled (scl_scaled),
      .scl_cum    (scl_cum),
      .scl_mask   (scl_mask),
      .scl_tag    (scl_tag)
   );

   // Category select and result register
   mwcd_pick #(
      .NUM_CATEGORIES (NUM_CATEGORIES),
      .SUM_WIDTH      (SUM_WIDTH)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .scl_valid  (scl_valid),
      .scl_ready  (scl_ready),
      .scl_scaled (scl_scaled),
      .scl_cum    (scl_cum),
      .scl_mask   (scl_mask),
      .scl_tag    (scl_tag),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

/* test/draw_checker.sv */
// Checker for the masked weighted category draw: predicts each result word and compares it.
`timescale 1ns / 1ps

module draw_checker #(
   parameter int NUM_CATEGORIES = mwcd_pkg::DEFAULT_NUM_CATEGORIES
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   mwcd_req_if                                       req_bus,
   mwcd_rsp_if                                       rsp_bus,
   input  wire logic                                 csr_we,
   input  wire logic [mwcd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [mwcd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                        fail_count,
   output int                                        pending_draws
);

   typedef struct packed {
      logic signed [mwcd_pkg::CAT_WIDTH-1:0] category;
      logic [mwcd_pkg::TAG_WIDTH-1:0]        tag;
   } draw_word_type;

   draw_word_type                     awaited_draws[$];
   logic [mwcd_pkg::WEIGHT_WIDTH-1:0] weight_copy[mwcd_pkg::MAX_CATEGORIES];

   // Walk the masked categories in index order and pick the first running sum
   // that the scaled draw does not pass; two masked categories use a strict test.
   function automatic logic signed [mwcd_pkg::CAT_WIDTH-1:0] pick_category(
      input logic [mwcd_pkg::MASK_WIDTH-1:0] mask,
      input logic [mwcd_pkg::DRAW_WIDTH-1:0] draw
   );
      logic [18:0] total;
      logic [18:0] running[mwcd_pkg::MAX_CATEGORIES];
      int          hit_index[mwcd_pkg::MAX_CATEGORIES];
      logic [34:0] product;
      logic [18:0] scaled;
      int          hits;
      int          j;
      int          w;
      total = '0;
      hits  = 0;
      for (j = 0; j < NUM_CATEGORIES && j < mwcd_pkg::MAX_CATEGORIES; j++) begin
         if (mask[j]) begin
            total           = total + weight_copy[j];
            hit_index[hits] = j;
            running[hits]   = total;
            hits++;
         end
      end
      product = draw * total;
      scaled  = product[34:16];
      if (hits == 0) begin
         return mwcd_pkg::NO_CATEGORY;
      end else if (hits == 1) begin
         return mwcd_pkg::CAT_WIDTH'(hit_index[0]);
      end else if (hits == 2) begin
         return (scaled < running[0]) ? mwcd_pkg::CAT_WIDTH'(hit_index[0])
                                      : mwcd_pkg::CAT_WIDTH'(hit_index[1]);
      end
      w = 0;
      while (w + 1 < hits && scaled > running[w]) w++;
      return mwcd_pkg::CAT_WIDTH'(hit_index[w]);
   endfunction

   // Track weights, queue a prediction per accepted read, check each result word
   always @(posedge clock) begin
      draw_word_type awaited;
      if (reset) begin
         for (int j = 0; j < mwcd_pkg::MAX_CATEGORIES; j++) begin
            weight_copy[j] = mwcd_pkg::WEIGHT_RESET;
         end
         awaited_draws.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            awaited.category = pick_category(req_bus.match_mask, req_bus.uniform_draw);
            awaited.tag      = req_bus.read_tag;
            awaited_draws.push_back(awaited);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_draws.size() == 0) begin
               $error("unexpected result word: category %0d, tag %0d",
                      rsp_bus.chosen_category, rsp_bus.tag_out);
               fail_count++;
            end else begin
               awaited = awaited_draws.pop_front();
               if (rsp_bus.chosen_category !== awaited.category) begin
                  $error("chosen_category: expected %0d, actual %0d",
                         awaited.category, rsp_bus.chosen_category);
                  fail_count++;
               end
               if (rsp_bus.tag_out !== awaited.tag) begin
                  $error("tag_out: expected %0d, actual %0d", awaited.tag, rsp_bus.tag_out);
                  fail_count++;
               end
            end
         end
         // Weights change only while idle, so apply after predicting
         if (csr_we && csr_index < mwcd_pkg::MAX_CATEGORIES) begin
            weight_copy[csr_index] = csr_wdata;
         end
      end
      pending_draws = awaited_draws.size();
   end

endmodule

/* test/tb_top.sv */
// Testbench top for the masked weighted category draw: drives reads, weights and stalls.
`timescale 1ns / 1ps

module tb_top;

   localparam int NUM_CATEGORIES   = mwcd_pkg::DEFAULT_NUM_CATEGORIES;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int PHASE_READS      = 150;

   typedef enum int {
      PROFILE_RANDOM,
      PROFILE_TINY,
      PROFILE_FULL_SCALE,
      PROFILE_SPARSE_ZERO,
      PROFILE_ALL_ZERO
   } weight_profile_type;

   typedef logic [mwcd_pkg::WEIGHT_WIDTH-1:0] weight_set_type[mwcd_pkg::MAX_CATEGORIES];

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_we;
   logic [mwcd_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [mwcd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;
   int                                   fail_count;
   int                                   pending_draws;
   logic                                 idling_on;
   logic                                 sender_gaps_on;
   logic                                 long_hold_req;

   mwcd_req_if req_bus ();
   mwcd_rsp_if rsp_bus ();

   masked_weighted_category_draw #(
      .NUM_CATEGORIES(NUM_CATEGORIES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   draw_checker #(
      .NUM_CATEGORIES(NUM_CATEGORIES)
   ) draw_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_draws (pending_draws)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop
   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

   // Result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_req = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Offer one read word, optionally after an idle burst; return at the negedge after acceptance
   task automatic push_read(
      input logic [mwcd_pkg::MASK_WIDTH-1:0] mask,
      input logic [mwcd_pkg::DRAW_WIDTH-1:0] draw,
      input logic [mwcd_pkg::TAG_WIDTH-1:0]  tag
   );
      int gap;
      if (sender_gaps_on && idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.match_mask   <= mask;
      req_bus.uniform_draw <= draw;
      req_bus.read_tag     <= tag;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Drop valid and hold until every pending result has come back
   task automatic drain_reads();
      req_bus.valid <= 1'b0;
      while (pending_draws != 0) @(negedge clock);
   endtask

   // Write all eight weights; call only while drained
   task automatic load_weights(input weight_set_type weights);
      int i;
      for (i = 0; i < mwcd_pkg::MAX_CATEGORIES; i++) begin
         csr_we    <= 1'b1;
         csr_index <= mwcd_pkg::CSR_INDEX_WIDTH'(mwcd_pkg::REG_WEIGHT_0 + i);
         csr_wdata <= weights[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_profile(input weight_profile_type profile);
      weight_set_type weights;
      int             i;
      for (i = 0; i < mwcd_pkg::MAX_CATEGORIES; i++) begin
         case (profile)
            PROFILE_TINY:        weights[i] = mwcd_pkg::WEIGHT_WIDTH'($urandom_range(0, 15));
            PROFILE_FULL_SCALE:  weights[i] = '1;
            PROFILE_SPARSE_ZERO: weights[i] = ($urandom_range(0, 1) == 0) ? '0
                                              : mwcd_pkg::WEIGHT_WIDTH'($urandom);
            PROFILE_ALL_ZERO:    weights[i] = '0;
            default:             weights[i] = mwcd_pkg::WEIGHT_WIDTH'($urandom);
         endcase
      end
      load_weights(weights);
   endtask

   // Random reads: mostly sparse masks and random ones, some extremes
   task automatic send_random_reads(input int count);
      logic [mwcd_pkg::MASK_WIDTH-1:0] mask;
      logic [mwcd_pkg::DRAW_WIDTH-1:0] draw;
      int                              i;
      for (i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: mask = mwcd_pkg::MASK_WIDTH'((1 << $urandom_range(0, 7))
                                            | (1 << $urandom_range(0, 7)));
            1: begin
               case ($urandom_range(0, 2))
                  0:       mask = '0;
                  1:       mask = '1;
                  default: mask = mwcd_pkg::MASK_WIDTH'(1 << $urandom_range(0, 7));
               endcase
            end
            default: mask = mwcd_pkg::MASK_WIDTH'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0:       draw = '0;
            1:       draw = '1;
            2:       draw = 16'h8000;
            default: draw = mwcd_pkg::DRAW_WIDTH'($urandom);
         endcase
         push_read(mask, draw, mwcd_pkg::TAG_WIDTH'($urandom));
      end
   endtask

   initial begin
      weight_set_type     weights;
      weight_profile_type phase_profile[6];
      int                 phase;

      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.match_mask   = '0;
      req_bus.uniform_draw = '0;
      req_bus.read_tag     = '0;
      idling_on            = 1'b1;
      sender_gaps_on       = 1'b1;
      long_hold_req        = 1'b0;
      phase_profile        = '{PROFILE_RANDOM, PROFILE_TINY, PROFILE_FULL_SCALE,
                               PROFILE_SPARSE_ZERO, PROFILE_ALL_ZERO, PROFILE_RANDOM};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset weights: empty mask, single category, strict two-way split, boundaries
      push_read(8'h00, 16'h1234, 16'h0000);
      push_read(8'h00, 16'hFFFF, 16'hFFFF);
      push_read(8'h01, 16'hFFFF, 16'h0001);
      push_read(8'h80, 16'h0000, 16'h0002);
      push_read(8'h03, 16'h7FFF, 16'h0003);
      push_read(8'h03, 16'h8000, 16'h0004);
      push_read(8'h81, 16'h0000, 16'h0005);
      push_read(8'h81, 16'hFFFF, 16'h0006);
      push_read(8'hFF, 16'h0000, 16'h0007);
      push_read(8'hFF, 16'd8192, 16'h0008);
      push_read(8'hFF, 16'd8193, 16'h0009);
      push_read(8'hFF, 16'hFFFF, 16'hAAAA);
      push_read(8'h15, 16'hAAAA, 16'h5555);
      push_read(8'hAA, 16'h5555, 16'h000D);

      // All weights zero: two masked picks the second, three or more the first
      drain_reads();
      weights = '{default: '0};
      load_weights(weights);
      push_read(8'h03, 16'hFFFF, 16'h0010);
      push_read(8'h07, 16'hFFFF, 16'h0011);
      push_read(8'h60, 16'h0000, 16'h0012);

      // Zero weights on masked categories mixed with full scale
      drain_reads();
      weights = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
      load_weights(weights);
      push_read(8'h07, 16'h0000, 16'h0020);
      push_read(8'h0F, 16'hFFFF, 16'h0021);
      push_read(8'h06, 16'h8000, 16'h0022);

      // All weights full scale
      drain_reads();
      weights = '{default: '1};
      load_weights(weights);
      push_read(8'hFF, 16'hFFFF, 16'h0030);
      push_read(8'h03, 16'h8000, 16'h0031);

      // Random phases, one weight profile each; the last one runs without idling
      for (phase = 0; phase < 6; phase++) begin
         drain_reads();
         if (phase == 5) idling_on = 1'b0;
         load_profile(phase_profile[phase]);
         if (phase == 1) begin
            // Hold off results while streaming reads so the pipeline fills and stalls
            long_hold_req  = 1'b1;
            sender_gaps_on = 1'b0;
            send_random_reads(20);
            sender_gaps_on = 1'b1;
         end
         send_random_reads(PHASE_READS);
      end

      drain_reads();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/mwcd_pkg.sv
rtl/mwcd_req_if.sv
rtl/mwcd_rsp_if.sv
rtl/mwcd_weights.sv
rtl/mwcd_accum.sv
rtl/mwcd_scale.sv
rtl/mwcd_pick.sv
rtl/masked_weighted_category_draw.sv
test/draw_checker.sv
test/tb_top.sv
